@@ rtl/core/sie_pkg.sv @@
// ============================================================================
// sie_pkg
// Shared types, constants and helpers of the shortest interval estimator.
// ============================================================================
package sie_pkg;

    // Field widths of the sample and result beats
    localparam int SAMPLE_W = 32;
    localparam int GAP_W    = 33;
    localparam int COV_W    = 16;

    // Fraction bits of the coverage register (unsigned Q0.16)
    localparam int COV_FRAC = 16;

    // Reset value of the coverage register, erf(1/sqrt2) in Q0.16
    localparam logic [COV_W-1:0] COV_RESET = 16'd44740;

    // Growth runs while the step budget is above this figure
    localparam int MIN_STEPS = 2;

    // Sequencer states
    typedef enum logic [3:0] {
        ST_LOAD,
        ST_START,
        ST_SCAN,
        ST_DRAIN,
        ST_FINAL,
        ST_PAIR_RD,
        ST_PAIR_CAP,
        ST_GROW_CHK,
        ST_GROW_GAP,
        ST_GROW_MOVE,
        ST_EMIT
    } sie_state_t;

    // Finished interval handed from the search engine to the output stage
    typedef struct packed {
        logic                valid;
        logic [SAMPLE_W-1:0] high;
        logic [SAMPLE_W-1:0] low;
    } sie_result_t;

    // Absolute difference of two signed samples, one bit wider than a sample
    function automatic logic [GAP_W-1:0] abs_gap(
        input logic [SAMPLE_W-1:0] a,
        input logic [SAMPLE_W-1:0] b
    );
        logic [GAP_W-1:0] d;
        d = {a[SAMPLE_W-1], a} - {b[SAMPLE_W-1], b};
        return d[GAP_W-1] ? (~d + GAP_W'(1)) : d;
    endfunction

endpackage

@@ rtl/core/sie_sample_mem.sv @@
// ============================================================================
// sie_sample_mem
// Sample store: one write port and two read ports, read data registered.
// ============================================================================
module sie_sample_mem #(
    parameter int DEPTH = 4096,
    parameter int AW    = 12
) (
    input  logic                         clk,
    input  logic                         we,
    input  logic [AW-1:0]                waddr,
    input  logic [sie_pkg::SAMPLE_W-1:0] wdata,
    input  logic                         re_a,
    input  logic [AW-1:0]                raddr_a,
    output logic [sie_pkg::SAMPLE_W-1:0] rdata_a,
    input  logic                         re_b,
    input  logic [AW-1:0]                raddr_b,
    output logic [sie_pkg::SAMPLE_W-1:0] rdata_b
);

    logic [sie_pkg::SAMPLE_W-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Read port A
    always_ff @(posedge clk)
    begin
        if (re_a)
        begin
            rdata_a <= mem[raddr_a];
        end
    end

    // Read port B
    always_ff @(posedge clk)
    begin
        if (re_b)
        begin
            rdata_b <= mem[raddr_b];
        end
    end

endmodule

@@ rtl/core/sie_search.sv @@
// ============================================================================
// sie_search
// Loads a sample set into the store, scans it for the narrowest neighbour
// gap and grows the interval around that pair one sample per step.
// ============================================================================
module sie_search #(
    parameter int MAX_SAMPLES = 4096,
    parameter int AW          = 12,
    parameter int CW          = 13
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [sie_pkg::SAMPLE_W-1:0] in_sample,
    input  logic                         in_last,
    input  logic [sie_pkg::COV_W-1:0]    coverage,
    input  logic                         out_free,
    output sie_pkg::sie_result_t         result
);

    localparam int PW = CW + sie_pkg::COV_W;

    // Control state
    sie_pkg::sie_state_t state_reg, state_next;
    logic [CW-1:0] count_reg, count_next;
    logic [AW-1:0] scan_idx_reg, scan_idx_next;
    logic [AW-1:0] left_reg, left_next;
    logic [AW-1:0] right_reg, right_next;
    logic [CW-1:0] steps_reg, steps_next;
    logic          d1_vld_reg, d1_vld_next;
    logic          gap_vld_reg, gap_vld_next;

    // Payload state
    logic [AW-1:0]                d1_idx_reg, d1_idx_next;
    logic [AW-1:0]                gap_idx_reg;
    logic [sie_pkg::GAP_W-1:0]    gap_reg;
    logic [sie_pkg::GAP_W-1:0]    min_reg;
    logic [AW-1:0]                best_reg;
    logic [sie_pkg::GAP_W-1:0]    full_reg;
    logic [sie_pkg::SAMPLE_W-1:0] first_reg;
    logic [sie_pkg::SAMPLE_W-1:0] prev_reg;
    logic [sie_pkg::SAMPLE_W-1:0] lo_val_reg, lo_val_next;
    logic [sie_pkg::SAMPLE_W-1:0] hi_val_reg, hi_val_next;
    logic [sie_pkg::GAP_W-1:0]    gap_l_reg, gap_l_next;
    logic [sie_pkg::GAP_W-1:0]    gap_r_reg, gap_r_next;

    // Memory ports
    logic                         mem_we;
    logic                         re_a, re_b;
    logic [AW-1:0]                raddr_a, raddr_b;
    logic [sie_pkg::SAMPLE_W-1:0] rdata_a, rdata_b;

    logic [CW-1:0] last_idx;
    logic          at_left_end, at_right_end;
    logic [PW-1:0] product;
    logic          store_room;

    assign last_idx     = count_reg - CW'(1);
    assign at_left_end  = (left_reg == '0);
    assign at_right_end = ({1'b0, right_reg} == last_idx);
    assign product      = PW'(count_reg) * PW'(coverage);
    assign store_room   = (count_reg < CW'(MAX_SAMPLES));
    assign in_ready     = (state_reg == sie_pkg::ST_LOAD);
    assign mem_we       = in_valid && in_ready && store_room;

    sie_sample_mem #(
        .DEPTH (MAX_SAMPLES),
        .AW    (AW)
    ) u_mem (
        .clk     (clk),
        .we      (mem_we),
        .waddr   (count_reg[AW-1:0]),
        .wdata   (in_sample),
        .re_a    (re_a),
        .raddr_a (raddr_a),
        .rdata_a (rdata_a),
        .re_b    (re_b),
        .raddr_b (raddr_b),
        .rdata_b (rdata_b)
    );

    // Sequencer: next state, memory reads and working registers
    always_comb
    begin
        state_next    = state_reg;
        count_next    = count_reg;
        scan_idx_next = scan_idx_reg;
        left_next     = left_reg;
        right_next    = right_reg;
        steps_next    = steps_reg;
        d1_vld_next   = 1'b0;
        d1_idx_next   = scan_idx_reg;
        lo_val_next   = lo_val_reg;
        hi_val_next   = hi_val_reg;
        gap_l_next    = gap_l_reg;
        gap_r_next    = gap_r_reg;
        re_a          = 1'b0;
        re_b          = 1'b0;
        raddr_a       = left_reg;
        raddr_b       = right_reg;
        result.valid  = 1'b0;
        result.low    = lo_val_reg;
        result.high   = hi_val_reg;

        unique case (state_reg)
            sie_pkg::ST_LOAD:
            begin
                if (in_valid)
                begin
                    if (store_room)
                    begin
                        count_next = count_reg + CW'(1);
                    end
                    if (in_last)
                    begin
                        state_next = sie_pkg::ST_START;
                    end
                end
            end

            sie_pkg::ST_START:
            begin
                // A single sample gives a zero-width interval at that sample
                if (count_reg < CW'(2))
                begin
                    left_next  = '0;
                    right_next = '0;
                    steps_next = '0;
                    state_next = sie_pkg::ST_PAIR_RD;
                end
                else
                begin
                    scan_idx_next = '0;
                    state_next    = sie_pkg::ST_SCAN;
                end
            end

            sie_pkg::ST_SCAN:
            begin
                re_a          = 1'b1;
                raddr_a       = scan_idx_reg;
                d1_vld_next   = 1'b1;
                scan_idx_next = scan_idx_reg + AW'(1);
                if ({1'b0, scan_idx_reg} == last_idx)
                begin
                    state_next = sie_pkg::ST_DRAIN;
                end
            end

            sie_pkg::ST_DRAIN:
            begin
                if (!d1_vld_reg && !gap_vld_reg)
                begin
                    state_next = sie_pkg::ST_FINAL;
                end
            end

            sie_pkg::ST_FINAL:
            begin
                // The whole range is the starting minimum: a pair must beat it
                left_next  = (min_reg < full_reg) ? best_reg : '0;
                right_next = ((min_reg < full_reg) ? best_reg : '0) + AW'(1);
                steps_next = product[PW-1:sie_pkg::COV_FRAC];
                state_next = sie_pkg::ST_PAIR_RD;
            end

            sie_pkg::ST_PAIR_RD:
            begin
                re_a       = 1'b1;
                re_b       = 1'b1;
                raddr_a    = left_reg;
                raddr_b    = right_reg;
                state_next = sie_pkg::ST_PAIR_CAP;
            end

            sie_pkg::ST_PAIR_CAP:
            begin
                lo_val_next = rdata_a;
                hi_val_next = rdata_b;
                state_next  = sie_pkg::ST_GROW_CHK;
            end

            sie_pkg::ST_GROW_CHK:
            begin
                if ((steps_reg <= CW'(sie_pkg::MIN_STEPS)) || (at_left_end && at_right_end))
                begin
                    state_next = sie_pkg::ST_EMIT;
                end
                else
                begin
                    // Fetch the outer neighbours of both ends
                    re_a       = 1'b1;
                    re_b       = 1'b1;
                    raddr_a    = left_reg - AW'(1);
                    raddr_b    = right_reg + AW'(1);
                    state_next = sie_pkg::ST_GROW_GAP;
                end
            end

            sie_pkg::ST_GROW_GAP:
            begin
                gap_l_next = sie_pkg::abs_gap(lo_val_reg, rdata_a);
                gap_r_next = sie_pkg::abs_gap(rdata_b, hi_val_reg);
                state_next = sie_pkg::ST_GROW_MOVE;
            end

            sie_pkg::ST_GROW_MOVE:
            begin
                // An end can only move the other way; a tie moves right
                if (!at_left_end && (at_right_end || (gap_l_reg < gap_r_reg)))
                begin
                    left_next   = left_reg - AW'(1);
                    lo_val_next = rdata_a;
                end
                else
                begin
                    right_next  = right_reg + AW'(1);
                    hi_val_next = rdata_b;
                end
                steps_next = steps_reg - CW'(1);
                state_next = sie_pkg::ST_GROW_CHK;
            end

            sie_pkg::ST_EMIT:
            begin
                if (out_free)
                begin
                    result.valid = 1'b1;
                    count_next   = '0;
                    state_next   = sie_pkg::ST_LOAD;
                end
            end

            default:
            begin
                state_next = sie_pkg::ST_LOAD;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= sie_pkg::ST_LOAD;
            count_reg    <= '0;
            scan_idx_reg <= '0;
            left_reg     <= '0;
            right_reg    <= '0;
            steps_reg    <= '0;
            d1_vld_reg   <= 1'b0;
            gap_vld_reg  <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            scan_idx_reg <= scan_idx_next;
            left_reg     <= left_next;
            right_reg    <= right_next;
            steps_reg    <= steps_next;
            d1_vld_reg   <= d1_vld_next;
            gap_vld_reg  <= gap_vld_next;
        end
    end

    // Scan stage one: neighbour gap of the sample just read
    assign gap_vld_next = d1_vld_reg && (d1_idx_reg != '0);

    always_ff @(posedge clk)
    begin
        d1_idx_reg <= d1_idx_next;
        if (d1_vld_reg)
        begin
            if (d1_idx_reg == '0)
            begin
                first_reg <= rdata_a;
            end
            gap_reg     <= sie_pkg::abs_gap(prev_reg, rdata_a);
            gap_idx_reg <= d1_idx_reg - AW'(1);
            prev_reg    <= rdata_a;
            if ({1'b0, d1_idx_reg} == last_idx)
            begin
                full_reg <= sie_pkg::abs_gap(first_reg, rdata_a);
            end
        end
    end

    // Scan stage two: running minimum, the first of equal gaps is kept
    always_ff @(posedge clk)
    begin
        if (gap_vld_reg && ((gap_idx_reg == '0) || (gap_reg < min_reg)))
        begin
            min_reg  <= gap_reg;
            best_reg <= gap_idx_reg;
        end
    end

    // Interval end values and growth gaps
    always_ff @(posedge clk)
    begin
        lo_val_reg <= lo_val_next;
        hi_val_reg <= hi_val_next;
        gap_l_reg  <= gap_l_next;
        gap_r_reg  <= gap_r_next;
    end

endmodule

@@ rtl/core/shortest_interval_estimator_unit.sv @@
// ============================================================================
// shortest_interval_estimator_unit
// Shortest coverage interval over a sorted set of Q16.16 samples.
// ============================================================================
// Usage:
// Samples arrive on the s_axis channel, one beat per cycle while ready, in
// ascending order; tlast marks the final sample of a set. Up to MAX_SAMPLES
// samples are kept in the sample store, further ones are dropped until tlast.
// After the tlast beat s_axis_tready stays low while the search runs: it
// starts, streams the store through the gap scan, drains the scan, settles
// the narrowest pair and reads it, runs the growth steps (about
// floor(N * coverage / 65536) - 2 steps), makes a closing check and hands
// off. The time from tlast to the result beat is set by the single read
// pass over the store and the read-compare loop of the growth; loading
// runs at one sample per cycle.
// The result leaves as one m_axis beat held in an output register; a new set
// may load while that beat waits, and a finished search holds until the
// register is free. The coverage register (reset 44740) is written through
// cfg_wr_en and cfg_wr_data; the user must write it only while the block
// is idle, and the block itself does not enforce this.
// Reset empties the store count and returns the block to loading.
// ============================================================================
module shortest_interval_estimator_unit #(
    parameter int MAX_SAMPLES = 4096
) (
    input  logic        clk,
    input  logic        rst_n,
    // sample_value [31:0]
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,
    input  logic        s_axis_tlast,
    // interval_low [31:0], interval_high [63:32]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [63:0] m_axis_tdata,
    // coverage_fraction [15:0]
    input  logic        cfg_wr_en,
    input  logic [15:0] cfg_wr_data
);

    localparam int AW = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1;
    localparam int CW = AW + 1;

    logic [sie_pkg::COV_W-1:0] coverage_reg;
    logic                      out_valid_reg;
    logic [63:0]               out_data_reg;
    logic                      out_free;
    sie_pkg::sie_result_t      result;

    assign out_free      = !out_valid_reg || m_axis_tready;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    sie_search #(
        .MAX_SAMPLES (MAX_SAMPLES),
        .AW          (AW),
        .CW          (CW)
    ) u_search (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_sample (s_axis_tdata),
        .in_last   (s_axis_tlast),
        .coverage  (coverage_reg),
        .out_free  (out_free),
        .result    (result)
    );

    // Coverage register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coverage_reg <= sie_pkg::COV_RESET;
        end
        else if (cfg_wr_en)
        begin
            coverage_reg <= cfg_wr_data;
        end
    end

    // Output beat valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (result.valid)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Output beat data
    always_ff @(posedge clk)
    begin
        if (result.valid)
        begin
            out_data_reg <= {result.high, result.low};
        end
    end

endmodule

@@ rtl/core/sie_checker.sv @@
// ============================================================================
// sie_checker
// Port-level checks of the shortest interval estimator.
// ============================================================================
module sie_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        s_axis_tlast,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [63:0] m_axis_tdata
);

    // A stalled result beat holds its data
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result beat changed while stalled");

    // The closing sample of a set starts the search, which blocks loading
    assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready && s_axis_tlast |=> !s_axis_tready)
        else $error("input still open after the closing sample");

    // Loading stops only after a closing sample
    assert property (@(posedge clk) disable iff (!rst_n)
        $fell(s_axis_tready) |-> $past(s_axis_tvalid && s_axis_tlast))
        else $error("input closed without a closing sample");

    // A result appears only at the end of a search, while loading was closed
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |-> $past(!s_axis_tready))
        else $error("result appeared while loading");

endmodule

bind shortest_interval_estimator_unit sie_checker u_sie_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

@@ tb/tb_shortest_interval_estimator_unit.sv @@
// ============================================================================
// tb_shortest_interval_estimator_unit
// Self-checking bench for the shortest coverage interval estimator.
// ============================================================================
// Sets of Q16.16 samples are sent as stream beats, with tlast on the final
// sample of each set. A scoreboard class keeps its own copy of the sample
// store and the coverage register. On each tlast beat it runs the narrowest-gap
// search and the greedy growth, and queues the expected bounds. Each result
// beat is compared against the oldest queued interval.
// The run starts with hand-picked sets: single samples, extreme values, ties,
// duplicates and unsorted data. Then random phases follow, each under its own
// coverage setting. One phase stalls the output side long enough to back the
// block up. Both sides idle in random bursts, except in the last phase.
// ============================================================================
module tb_shortest_interval_estimator_unit;

    localparam int DEPTH        = 4096;
    localparam int LIMIT_CYCLES = 1000000;
    localparam int PHASE_BEATS  = 185;
    localparam int NUM_PHASES   = 6;

    // Scoreboard: mirrors the sample store and predicts each interval.
    class interval_scoreboard;

        typedef struct packed {
            logic [sie_pkg::SAMPLE_W-1:0] high;
            logic [sie_pkg::SAMPLE_W-1:0] low;
        } bounds_t;

        logic [sie_pkg::SAMPLE_W-1:0] samples [DEPTH];
        int unsigned                  n_stored;
        logic [sie_pkg::COV_W-1:0]    coverage;
        bounds_t                      pending_intervals [$];
        int unsigned                  errors;
        int unsigned                  compared;
        int unsigned                  beats;

        function new();
            n_stored = 0;
            coverage = sie_pkg::COV_RESET;
            errors   = 0;
            compared = 0;
            beats    = 0;
        endfunction

        // Absolute difference of two stored samples, wide enough for any pair.
        function longint span(int a, int b);
            longint d;
            d = longint'($signed(samples[b])) - longint'($signed(samples[a]));
            return (d < 0) ? -d : d;
        endfunction

        // Narrowest neighbouring pair, then greedy growth towards the smaller gap.
        function void search_set();
            int      n;
            int      lo;
            int      hi;
            longint  best;
            longint  g;
            longint  budget;
            bounds_t b;
            n  = n_stored;
            lo = 0;
            hi = 0;
            if (n >= 2)
            begin
                best = span(0, n - 1);
                for (int i = 0; i + 1 < n; i++)
                begin
                    g = span(i, i + 1);
                    if (g < best)
                    begin
                        best = g;
                        lo   = i;
                    end
                end
                hi     = lo + 1;
                budget = ((longint'(n) * longint'(coverage)) >>> sie_pkg::COV_FRAC)
                         - sie_pkg::MIN_STEPS;
                while (budget > 0 && !(lo == 0 && hi == n - 1))
                begin
                    if (lo == 0)
                        hi++;
                    else if (hi == n - 1)
                        lo--;
                    else if (span(lo - 1, lo) < span(hi, hi + 1))
                        lo--;
                    else
                        hi++;
                    budget--;
                end
            end
            b.low  = samples[lo];
            b.high = samples[hi];
            pending_intervals.insert(pending_intervals.size(), b);
        endfunction

        // An accepted sample beat: store it, and close the set on tlast.
        function void note_sample(logic [sie_pkg::SAMPLE_W-1:0] value, logic is_last);
            beats++;
            if (n_stored < DEPTH)
            begin
                samples[n_stored] = value;
                n_stored++;
            end
            if (is_last)
            begin
                search_set();
                n_stored = 0;
            end
        endfunction

        task report(string what, logic [sie_pkg::SAMPLE_W-1:0] got,
                    logic [sie_pkg::SAMPLE_W-1:0] want);
            $display("MISMATCH %s: got %h, want %h (beat %0d)", what, got, want, compared);
            errors++;
        endtask

        // An accepted result beat, compared against the oldest prediction.
        task check_interval(logic [sie_pkg::SAMPLE_W-1:0] low,
                            logic [sie_pkg::SAMPLE_W-1:0] high);
            bounds_t want;
            if (pending_intervals.size() == 0)
            begin
                report("result beat with no interval pending, low", low, '0);
            end
            else
            begin
                want = pending_intervals.pop_front();
                if (low !== want.low)
                    report("interval_low", low, want.low);
                if (high !== want.high)
                    report("interval_high", high, want.high);
            end
            compared++;
        endtask

    endclass

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata;
    logic        s_axis_tlast;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [63:0] m_axis_tdata;
    logic        cfg_wr_en;
    logic [15:0] cfg_wr_data;

    interval_scoreboard sb;
    bit                 idling_on;
    bit                 tx_bursty;
    int                 hold_off_cycles;
    int                 n_sets;
    int                 n_cov_writes;
    int unsigned        cycle_count;

    shortest_interval_estimator_unit #(
        .MAX_SAMPLES (DEPTH)
    ) u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data)
    );

    // Clock generation.
    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Cycle counter with a hard limit on the run.
    initial
    begin
        cycle_count = 0;
        while (cycle_count < LIMIT_CYCLES)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Timeout after %0d cycles, %0d intervals still pending",
                 cycle_count, sb.pending_intervals.size());
        $display("CHECKS FAILED");
        $finish;
    end

    // Output side: random stall bursts, quiet stretches and one long hold-off.
    initial
    begin
        int stall_left;
        int mode_left;
        bit stalls_on;
        stall_left    = 0;
        mode_left     = 0;
        stalls_on     = 1'b1;
        m_axis_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (mode_left == 0)
            begin
                stalls_on = ($urandom_range(0, 3) != 0);
                mode_left = 64;
            end
            mode_left--;
            if (hold_off_cycles > 0)
            begin
                m_axis_tready = 1'b0;
                hold_off_cycles--;
            end
            else if (stall_left > 0)
            begin
                m_axis_tready = 1'b0;
                stall_left--;
            end
            else if (idling_on && stalls_on && $urandom_range(0, 5) == 0)
            begin
                stall_left    = $urandom_range(1, 17) - 1;
                m_axis_tready = 1'b0;
            end
            else
            begin
                m_axis_tready = 1'b1;
            end
        end
    end

    // Result monitor.
    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_interval(m_axis_tdata[31:0], m_axis_tdata[63:32]);
    end

    // Offer one sample beat, possibly after an idle burst, and wait for acceptance.
    task send_sample(input logic [31:0] value, input logic is_last);
        @(negedge clk);
        if (idling_on && tx_bursty && $urandom_range(0, 4) == 0)
        begin
            s_axis_tvalid = 1'b0;
            s_axis_tdata  = $urandom;
            s_axis_tlast  = 1'($urandom_range(0, 1));
            repeat ($urandom_range(1, 17)) @(negedge clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tdata  = value;
        s_axis_tlast  = is_last;
        do
            @(posedge clk);
        while (!s_axis_tready);
        sb.note_sample(value, is_last);
    endtask

    task send_set(input int vals[$]);
        tx_bursty = ($urandom_range(0, 2) != 0);
        foreach (vals[i])
            send_sample(vals[i], i == vals.size() - 1);
        n_sets++;
    endtask

    task park_sender();
        @(negedge clk);
        s_axis_tvalid = 1'b0;
        s_axis_tlast  = 1'b0;
    endtask

    // Wait until every interval has come out, plus a settling margin.
    task wait_drained();
        while (sb.pending_intervals.size() != 0)
            @(posedge clk);
        repeat (16) @(posedge clk);
    endtask

    task write_coverage(input logic [15:0] value);
        park_sender();
        wait_drained();
        @(negedge clk);
        cfg_wr_en   = 1'b1;
        cfg_wr_data = value;
        @(posedge clk);
        sb.coverage = value;
        n_cov_writes++;
        @(negedge clk);
        cfg_wr_en   = 1'b0;
        cfg_wr_data = 16'($urandom);
    endtask

    // Random set: mostly sorted, some clustered or evenly spaced, a few unsorted.
    function void make_set(int n, output int vals[$]);
        int kind;
        int base;
        int stride;
        vals   = {};
        kind   = $urandom_range(0, 9);
        base   = $urandom;
        stride = $urandom_range(0, 3) << $urandom_range(0, 20);
        for (int i = 0; i < n; i++)
        begin
            if (kind <= 4 || kind == 8)
                vals.insert(vals.size(), $urandom);
            else if (kind <= 7)
                vals.insert(vals.size(), base + $urandom_range(0, 7) * (stride + 1));
            else
                vals.insert(vals.size(), base + i * stride);
        end
        if (kind != 8)
            vals.sort();
    endfunction

    function int pick_size();
        int r;
        r = $urandom_range(0, 19);
        if (r == 0)
            return 1;
        else if (r == 1)
            return 2;
        else if (r <= 16)
            return $urandom_range(3, 12);
        else if (r <= 18)
            return $urandom_range(13, 40);
        return $urandom_range(41, 120);
    endfunction

    // Main sequence.
    initial
    begin
        int          vals[$];
        int          sent;
        logic [15:0] cov_list [NUM_PHASES];
        sb              = new();
        idling_on       = 1'b1;
        tx_bursty       = 1'b0;
        hold_off_cycles = 0;
        n_sets          = 0;
        n_cov_writes    = 0;
        rst_n           = 1'b0;
        s_axis_tvalid   = 1'b0;
        s_axis_tdata    = '0;
        s_axis_tlast    = 1'b0;
        cfg_wr_en       = 1'b0;
        cfg_wr_data     = '0;
        repeat (2) @(negedge clk);
        rst_n = 1'b1;

        // Hand-picked sets under the reset coverage setting.
        send_set('{int'(32'h8000_0000)});
        send_set('{int'(32'h8000_0000), int'(32'h7FFF_FFFF)});
        send_set('{0, 10, 20, 30, 40});
        send_set('{-5, -5, -5});
        send_set('{100, -100, 50, int'(32'h7FFF_FFFF)});
        send_set('{0, 1, 100, 200, 400});
        send_set('{-1000, -400, -100, 0, 1});

        // Random phases, each under its own coverage setting.
        cov_list[0] = 16'hFFFF;
        cov_list[1] = 16'h0000;
        cov_list[2] = 16'h8000;
        cov_list[3] = 16'($urandom_range(0, 65535));
        cov_list[4] = 16'd60000;
        cov_list[5] = 16'($urandom_range(0, 65535));
        for (int p = 0; p < NUM_PHASES; p++)
        begin
            write_coverage(cov_list[p]);
            if (p == NUM_PHASES - 1)
                idling_on = 1'b0;
            if (p == 4)
                hold_off_cycles = 600;
            sent = 0;
            while (sent < PHASE_BEATS)
            begin
                make_set(pick_size(), vals);
                send_set(vals);
                sent += vals.size();
            end
        end

        park_sender();
        while (sb.pending_intervals.size() != 0)
            @(posedge clk);
        repeat (64) @(posedge clk);

        $display("Run covered %0d sample beats in %0d sets and %0d compared intervals,",
                 sb.beats, n_sets, sb.compared);
        $display("under %0d coverage writes, random idling on both sides and a long output stall.",
                 n_cov_writes);
        if (sb.errors == 0 && sb.pending_intervals.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
